FILE: sv/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared types and codes for the software timer table
// Word formats for the request and response channels, the table entry
// layout, and the opcode and result kind codes.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Request opcodes
  localparam logic [1:0] OP_TICK         = 2'd0;
  localparam logic [1:0] OP_ADD_PERIODIC = 2'd1;
  localparam logic [1:0] OP_ADD_ONESHOT  = 2'd2;

  // Response kinds
  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;

  // Most responses reported for one tick; further expiries are silent
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  handler_id;
    logic [31:0] tick_count;
  } req_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] fired_handler;
    logic       last;
  } rsp_word_t;

  // One timer entry; reload of zero marks a one-shot timer
  typedef struct packed {
    logic [7:0]  handler;
    logic [31:0] reload;
    logic [31:0] counter;
  } entry_t;

endpackage

FILE: sv/software_timer_table.sv
// ----------------------------------------------------------------------------
// software_timer_table: ordered table of periodic and one-shot timers
// Top level joining the table memory and its sequencer.
// ----------------------------------------------------------------------------
// An add is accepted in the idle state and its response word passes through the
// pending stage into the output register. A tick walks the table (and waits
// while a stalled response holds it): the sequencer reads an entry through the
// registered read port in S_READ, then updates it and writes it back through the
// write port in S_PROC, closing up removed one-shot entries as it goes.
// No new request is taken until the current one has handed off its last word.
// The table needs no clearing after reset; it is used from the first cycle.
module software_timer_table
  import stt_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_entry;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_entry;

  // Timer table storage
  stt_mem #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  // Sequencer
  stt_ctrl #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_entry  (wr_entry),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_entry  (rd_entry)
  );

endmodule

FILE: sv/stt_mem.sv
// ----------------------------------------------------------------------------
// stt_mem: timer table storage
// One write port and one read port; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module stt_mem
  import stt_pkg::*;
#(
  parameter int SLOTS = 16,
  parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_entry,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_entry
);

  entry_t table_mem [SLOTS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_entry;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= table_mem[rd_addr];
    end
  end

endmodule

FILE: sv/stt_ctrl.sv
// ----------------------------------------------------------------------------
// stt_ctrl: timer table sequencer
// Appends timers, walks the table on a tick with a read pointer and a
// compacting write pointer, and delivers response words through a
// pending stage and an output register.
// ----------------------------------------------------------------------------
module stt_ctrl
  import stt_pkg::*;
#(
  parameter int SLOTS = 16,
  parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  parameter int CNT_W = $clog2(SLOTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_word_t        req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_word_t        rsp,
  output logic             wr_en,
  output logic [IDX_W-1:0] wr_addr,
  output entry_t           wr_entry,
  output logic             rd_en,
  output logic [IDX_W-1:0] rd_addr,
  input  entry_t           rd_entry
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_PROC  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     occ;        // occupied entries
  logic [CNT_W-1:0]     rptr;       // walk read pointer
  logic [CNT_W-1:0]     wptr;       // walk write pointer (compaction)
  logic [RES_CNT_W-1:0] nres;       // responses reported in this tick
  logic                 pend_valid;
  logic [1:0]           pend_kind;
  logic [7:0]           pend_handler;

  logic                 req_acc;
  logic                 is_add;
  logic                 add_ok;
  logic                 out_free;
  logic [31:0]          dec;
  logic                 fire;
  logic                 keep;
  logic                 emit;
  logic                 proc_go;
  logic [CNT_W-1:0]     rptr_inc;
  logic [CNT_W-1:0]     wptr_next;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign is_add    = (req.opcode == OP_ADD_PERIODIC) || (req.opcode == OP_ADD_ONESHOT);
  assign add_ok    = (occ < CNT_W'(SLOTS)) && (req.tick_count != 32'd0);
  assign out_free  = !rsp_valid || !rsp_stall;

  // Per-entry tick update
  assign dec       = rd_entry.counter - 32'd1;
  assign fire      = (dec == 32'd0);
  assign keep      = !fire || (rd_entry.reload != 32'd0);
  assign emit      = fire && (nres < RES_CNT_W'(MAX_RESULTS));
  assign proc_go   = !(emit && pend_valid && !out_free);
  assign rptr_inc  = rptr + CNT_W'(1);
  assign wptr_next = keep ? (wptr + CNT_W'(1)) : wptr;

  // Table access
  assign rd_en   = (state == S_READ);
  assign rd_addr = rptr[IDX_W-1:0];

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = wptr[IDX_W-1:0];
    wr_entry = rd_entry;
    if (state == S_IDLE) begin
      wr_en            = req_acc && is_add && add_ok;
      wr_addr          = occ[IDX_W-1:0];
      wr_entry.handler = req.handler_id;
      wr_entry.reload  = (req.opcode == OP_ADD_PERIODIC) ? req.tick_count : 32'd0;
      wr_entry.counter = req.tick_count;
    end else if (state == S_PROC) begin
      wr_en            = proc_go && keep;
      wr_entry.counter = fire ? rd_entry.reload : dec;
    end
  end

  // Sequencer and pending response
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      occ        <= '0;
      rptr       <= '0;
      wptr       <= '0;
      nres       <= '0;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_acc) begin
            rptr <= '0;
            wptr <= '0;
            nres <= '0;
            if (req.opcode == OP_TICK) begin
              state <= (occ == '0) ? S_FLUSH : S_READ;
            end else if (is_add) begin
              pend_valid   <= 1'b1;
              pend_kind    <= add_ok ? KIND_ACCEPT : KIND_REJECT;
              pend_handler <= 8'd0;
              if (add_ok) begin
                occ <= occ + CNT_W'(1);
              end
              state <= S_FLUSH;
            end
          end
        end
        S_READ: begin
          state <= S_PROC;
        end
        S_PROC: begin
          if (proc_go) begin
            if (emit) begin
              pend_valid   <= 1'b1;
              pend_kind    <= KIND_FIRED;
              pend_handler <= rd_entry.handler;
              nres         <= nres + RES_CNT_W'(1);
            end
            wptr <= wptr_next;
            rptr <= rptr_inc;
            if (rptr_inc == occ) begin
              occ   <= wptr_next;
              state <= S_FLUSH;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: loads pending word on a new emit or in S_FLUSH (last)
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_PROC && proc_go && emit && pend_valid) begin
      rsp_valid         <= 1'b1;
      rsp.kind          <= pend_kind;
      rsp.fired_handler <= pend_handler;
      rsp.last          <= 1'b0;
    end else if (state == S_FLUSH && pend_valid && out_free) begin
      rsp_valid         <= 1'b1;
      rsp.kind          <= pend_kind;
      rsp.fired_handler <= pend_handler;
      rsp.last          <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Checks
  a_compact_behind: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROC) |-> (wptr <= rptr) && (rptr < occ))
    else $error("walk pointers out of order");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(SLOTS))
    else $error("occupancy above table size");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("pending response left in idle");

  a_res_cap: assert property (@(posedge clk) disable iff (rst)
    nres <= RES_CNT_W'(MAX_RESULTS))
    else $error("response count above cap");

endmodule
